### rtl/core/uitp_pkg.sv
// ============================================================================
// uitp_pkg - shared types and constants of the unsigned integer text parser
// Holds the word types of both channels, the character constants, the
// configuration register indexes and the result width limit function.
// ============================================================================
package uitp_pkg;

    // One input word: a single character of the string.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       empty_string;
    } in_word_t;

    // One result word, produced on the final character of a string.
    typedef struct packed {
        logic [63:0] parsed_value;
        logic        parse_ok;
    } out_word_t;

    // Classification of one character.
    typedef struct packed {
        logic       is_sep;
        logic       is_digit;
        logic [3:0] digit;
    } char_class_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_HEX_MODE     = 1'b0,
        CFG_WIDTH_SELECT = 1'b1
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W = 2;

    // Result width codes.
    localparam logic [1:0] WSEL_8  = 2'd0;
    localparam logic [1:0] WSEL_16 = 2'd1;
    localparam logic [1:0] WSEL_32 = 2'd2;
    localparam logic [1:0] WSEL_64 = 2'd3;

    // Characters of interest.
    localparam logic [7:0] CHAR_SEP  = 8'h27;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_UC_A = 8'h41;
    localparam logic [7:0] CHAR_UC_F = 8'h46;
    localparam logic [7:0] CHAR_X    = 8'h78;

    // Hex prefix progress.
    localparam logic [1:0] PFX_WANT_ZERO = 2'd0;
    localparam logic [1:0] PFX_WANT_X    = 2'd1;
    localparam logic [1:0] PFX_DONE      = 2'd2;

    // Largest value representable at the selected width.
    function automatic logic [63:0] width_max(input logic [1:0] sel);
        logic [63:0] max_val;
        unique case (sel)
            WSEL_8:  max_val = 64'h0000_0000_0000_00FF;
            WSEL_16: max_val = 64'h0000_0000_0000_FFFF;
            WSEL_32: max_val = 64'h0000_0000_FFFF_FFFF;
            default: max_val = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return max_val;
    endfunction

endpackage

### rtl/core/uitp_char_class.sv
// ============================================================================
// uitp_char_class - character classifier
// Decodes one character into separator, digit flag and digit value.
// ============================================================================
module uitp_char_class
(
    input  logic [7:0]            char_code,
    input  logic                  hex_mode,
    output uitp_pkg::char_class_t char_class
);

    logic is_dec;
    logic is_hex_letter;

    assign is_dec        = (char_code >= uitp_pkg::CHAR_ZERO) &&
                           (char_code <= uitp_pkg::CHAR_NINE);
    assign is_hex_letter = hex_mode &&
                           (char_code >= uitp_pkg::CHAR_UC_A) &&
                           (char_code <= uitp_pkg::CHAR_UC_F);

    always_comb
    begin
        char_class.is_sep   = (char_code == uitp_pkg::CHAR_SEP);
        char_class.is_digit = is_dec || is_hex_letter;
        if (is_dec)
        begin
            char_class.digit = 4'(char_code - uitp_pkg::CHAR_ZERO);
        end
        else if (is_hex_letter)
        begin
            char_class.digit = 4'(char_code - uitp_pkg::CHAR_UC_A) + 4'd10;
        end
        else
        begin
            char_class.digit = 4'd0;
        end
    end

endmodule

### rtl/core/uitp_step.sv
// ============================================================================
// uitp_step - per-character parse step
// Holds the string state and applies one character to it per firing cycle.
// On the final character it presents the result and clears the state.
// ============================================================================
module uitp_step
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  uitp_pkg::in_word_t   item,
    input  logic                 hex_mode,
    input  logic [1:0]           width_select,
    output uitp_pkg::out_word_t  result
);

    logic [63:0] acc_reg,      acc_next;
    logic        prev_sep_reg, prev_sep_next;
    logic        err_reg,      err_next;
    logic [1:0]  prefix_reg,   prefix_next;

    // State after this character, before the end-of-string clear.
    logic [63:0] acc_upd;
    logic        prev_sep_upd;
    logic        err_upd;
    logic [1:0]  prefix_upd;

    uitp_pkg::char_class_t cls;
    logic [63:0] max_val;
    logic [67:0] acc_wide;
    logic [67:0] scaled;
    logic [67:0] candidate;
    logic        overflow;
    logic        in_prefix;
    logic [7:0]  want_char;
    logic        char_ok;
    logic        ok;

    uitp_char_class u_char_class
    (
        .char_code  (item.char_code),
        .hex_mode   (hex_mode),
        .char_class (cls)
    );

    assign max_val   = uitp_pkg::width_max(width_select);
    assign acc_wide  = {4'd0, acc_reg};
    assign scaled    = hex_mode ? (acc_wide << 4) : ((acc_wide << 3) + (acc_wide << 1));
    assign candidate = scaled + {64'd0, cls.digit};
    // Exact: acc * base + digit must not exceed the limit.
    assign overflow  = (acc_reg > max_val) || (candidate > {4'd0, max_val});
    assign in_prefix = hex_mode && (prefix_reg != uitp_pkg::PFX_DONE);
    assign want_char = (prefix_reg == uitp_pkg::PFX_WANT_ZERO) ? uitp_pkg::CHAR_ZERO
                                                               : uitp_pkg::CHAR_X;
    assign char_ok   = cls.is_digit || (cls.is_sep && !prev_sep_reg);

    always_comb
    begin
        acc_upd      = acc_reg;
        prev_sep_upd = prev_sep_reg;
        err_upd      = err_reg;
        prefix_upd   = prefix_reg;
        if (in_prefix)
        begin
            if (item.char_code != want_char)
            begin
                err_upd = 1'b1;
            end
            prefix_upd = prefix_reg + 2'd1;
        end
        else if (!char_ok)
        begin
            err_upd = 1'b1;
        end
        else
        begin
            prev_sep_upd = cls.is_sep;
            if (!cls.is_sep && !err_reg)
            begin
                if (overflow)
                begin
                    err_upd = 1'b1;
                end
                else
                begin
                    acc_upd = candidate[63:0];
                end
            end
        end
    end

    // The value only grows when the new value fits and the old one already did,
    // so the end-of-string range check can look at the stored value.
    always_comb
    begin
        ok = !err_upd && !prev_sep_upd && (acc_reg <= max_val);
        if (hex_mode && (prefix_upd != uitp_pkg::PFX_DONE))
        begin
            ok = 1'b0;
        end
        if (item.empty_string)
        begin
            ok = 1'b0;
        end
        result.parse_ok     = ok;
        result.parsed_value = ok ? acc_upd : 64'd0;
    end

    always_comb
    begin
        acc_next      = acc_reg;
        prev_sep_next = prev_sep_reg;
        err_next      = err_reg;
        prefix_next   = prefix_reg;
        if (fire)
        begin
            if (item.last_char)
            begin
                acc_next      = 64'd0;
                prev_sep_next = 1'b1;
                err_next      = 1'b0;
                prefix_next   = uitp_pkg::PFX_WANT_ZERO;
            end
            else
            begin
                acc_next      = acc_upd;
                prev_sep_next = prev_sep_upd;
                err_next      = err_upd;
                prefix_next   = prefix_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= 64'd0;
            prev_sep_reg <= 1'b1;
            err_reg      <= 1'b0;
            prefix_reg   <= uitp_pkg::PFX_WANT_ZERO;
        end
        else
        begin
            acc_reg      <= acc_next;
            prev_sep_reg <= prev_sep_next;
            err_reg      <= err_next;
            prefix_reg   <= prefix_next;
        end
    end

endmodule

### rtl/core/unsigned_int_text_parser.sv
// ============================================================================
// unsigned_int_text_parser - streaming unsigned integer text parser
// Parses a decimal or 0x-prefixed hexadecimal string, one character per word,
// with apostrophe digit separators and exact overflow checking at 8, 16, 32
// or 64 bits, and delivers the value with an ok flag on the final character.
// ============================================================================
//
//   Channel | Direction | Handshake           | Word
//   --------+-----------+---------------------+-------------------------------
//   in      | input     | in_valid / in_stall | char_code, last_char,
//           |           |                     | empty_string
//   out     | output    | out_valid/out_stall | parsed_value, parse_ok
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One character word is accepted per cycle while in_stall is low. A word
// sits in the input register while the parse step applies it to the string
// state; the result of a final character is loaded into the output register
// when the step fires, and is offered on the out channel from there.
// Reset clears the string state and sets decimal mode at 64 bits.
// A waiting result stalls only a final character behind it; other characters
// keep flowing. Configuration writes are always taken.
//
// The whole string state (value, separator flag, sticky error, prefix
// progress) updates in the cycle a character leaves the input register, so
// consecutive characters follow back to back with no bubble.
module unsigned_int_text_parser
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  uitp_pkg::in_word_t            in_data,

    output logic                          out_valid,
    input  logic                          out_stall,
    output uitp_pkg::out_word_t           out_data,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  uitp_pkg::cfg_index_t          cfg_index,
    input  logic [uitp_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic       hex_mode_reg,     hex_mode_next;
    logic [1:0] width_select_reg, width_select_next;

    // Input register.
    logic               s1_valid_reg, s1_valid_next;
    uitp_pkg::in_word_t s1_word_reg,  s1_word_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    uitp_pkg::out_word_t out_word_reg,  out_word_next;

    uitp_pkg::out_word_t step_result;
    logic                in_accept;
    logic                step_fire;
    logic                out_free;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        hex_mode_next     = hex_mode_reg;
        width_select_next = width_select_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                uitp_pkg::CFG_HEX_MODE:     hex_mode_next     = cfg_data[0];
                uitp_pkg::CFG_WIDTH_SELECT: width_select_next = cfg_data[1:0];
                default:                    hex_mode_next     = hex_mode_reg;
            endcase
        end
    end

    // The output register can take a new result when empty or being drained.
    assign out_free  = !out_valid_reg || !out_stall;
    // A non-final character needs no output slot.
    assign step_fire = s1_valid_reg && (!s1_word_reg.last_char || out_free);
    assign in_stall  = s1_valid_reg && !step_fire;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_word_next  = s1_word_reg;
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_word_next  = in_data;
            s1_valid_next = 1'b1;
        end
        else if (step_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    uitp_step u_step
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (step_fire),
        .item         (s1_word_reg),
        .hex_mode     (hex_mode_reg),
        .width_select (width_select_reg),
        .result       (step_result)
    );

    always_comb
    begin
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg;
        if (step_fire && s1_word_reg.last_char)
        begin
            out_word_next  = step_result;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_mode_reg     <= 1'b0;
            width_select_reg <= uitp_pkg::WSEL_64;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            hex_mode_reg     <= hex_mode_next;
            width_select_reg <= width_select_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg  <= s1_word_next;
        out_word_reg <= out_word_next;
    end

endmodule
